[rtl/acb_pkg.sv]
// Shared types, constants and codes for the adaptive command batcher.
package acb_pkg;

  localparam int SLOTS_DEFAULT        = 16;
  localparam int PAYLOAD_BITS_DEFAULT = 64;
  localparam int QUEUE_DEPTH          = 2;

  localparam int WORD_BITS      = 64;
  localparam int IN_ID_BITS     = 8;
  localparam int RES_ID_BITS    = 4;
  localparam int THRESHOLD_BITS = 5;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic        BATCH_ENABLE_RESET = 1'b1;
  localparam logic [7:0]  FLUSH_DROPS_RESET  = 8'd4;
  localparam logic [15:0] INTERVAL_RESET     = 16'd250;

  localparam logic KIND_COMMAND = 1'b0;
  localparam logic KIND_TICK    = 1'b1;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_BATCH_ENABLE    = 2'd0,
    REG_FLUSH_DROPS     = 2'd1,
    REG_UPDATE_INTERVAL = 2'd2
  } acb_reg_e;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_PASS  = 2'd1,
    OP_BATCH = 2'd2
  } acb_op_e;

  typedef struct packed {
    logic                   kind;
    logic [IN_ID_BITS-1:0]  robot_id;
    logic [WORD_BITS-1:0]   command_word;
  } cmd_t;

  typedef struct packed {
    logic [RES_ID_BITS-1:0]    robot_id_res;
    logic [WORD_BITS-1:0]      command_word_res;
    logic                      last;
    logic                      forced;
    logic [THRESHOLD_BITS-1:0] threshold_now;
  } res_t;

  typedef struct packed {
    logic        batch_enable;
    logic [7:0]  flush_drops;
    logic [15:0] update_interval_ms;
  } acb_cfg_t;

  typedef struct packed {
    logic    valid;
    acb_op_e op;
  } acb_head_t;

endpackage

[rtl/acb_front.sv]
// Front end: classifies incoming items and holds them in a short queue.
module acb_front
  import acb_pkg::*;
#(
  parameter int SLOTS        = SLOTS_DEFAULT,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_valid,
  output logic                      cmd_stall,
  input  cmd_t                      cmd,
  input  logic                      batch_enable,
  output acb_head_t                 head,
  output logic [$clog2(SLOTS)-1:0]  head_id,
  output logic [PAYLOAD_BITS-1:0]   head_word,
  input  logic                      head_pop
);

  localparam int IDW  = $clog2(SLOTS);
  localparam int PTRW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW   = $clog2(QUEUE_DEPTH + 1);

  acb_op_e                 q_op   [QUEUE_DEPTH];
  logic [IDW-1:0]          q_id   [QUEUE_DEPTH];
  logic [PAYLOAD_BITS-1:0] q_word [QUEUE_DEPTH];

  logic [PTRW-1:0] wr_ptr;
  logic [PTRW-1:0] rd_ptr;
  logic [CW-1:0]   count;

  acb_op_e op_in;
  logic    keep;
  logic    push;
  logic    pop;

  assign cmd_stall = (count == CW'(QUEUE_DEPTH));

  always_comb begin
    keep  = 1'b1;
    op_in = OP_TICK;
    if (cmd.kind == KIND_TICK) begin
      op_in = OP_TICK;
    end else begin
      keep  = (int'(cmd.robot_id) < SLOTS);
      op_in = batch_enable ? OP_BATCH : OP_PASS;
    end
  end

  assign push = cmd_valid && !cmd_stall && keep;
  assign pop  = head_pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.op    = q_op[rd_ptr];
  assign head_id    = q_id[rd_ptr];
  assign head_word  = q_word[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_op[wr_ptr]   <= op_in;
      q_id[wr_ptr]   <= cmd.robot_id[IDW-1:0];
      q_word[wr_ptr] <= cmd.command_word[PAYLOAD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTRW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTRW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTRW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTRW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/acb_back.sv]
// Back end: slot buffer, drop and threshold logic, flush sequencer, result register.
module acb_back
  import acb_pkg::*;
#(
  parameter int SLOTS        = SLOTS_DEFAULT,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  acb_cfg_t                  cfg,
  input  acb_head_t                 head,
  input  logic [$clog2(SLOTS)-1:0]  head_id,
  input  logic [PAYLOAD_BITS-1:0]   head_word,
  output logic                      head_pop,
  output logic                      res_valid,
  input  logic                      res_stall,
  output res_t                      res
);

  localparam int IDW = $clog2(SLOTS);
  localparam int TW  = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SEND
  } state_t;

  state_t                  state;
  logic [SLOTS-1:0]        filled;
  logic [SLOTS-1:0]        seen;
  logic [7:0]              drop_count;
  logic [TW-1:0]           fill_count;
  logic [TW-1:0]           seen_count;
  logic [TW-1:0]           threshold;
  logic [15:0]             ms_since_update;
  logic [SLOTS-1:0]        remaining;
  logic                    flush_forced;
  logic [IDW-1:0]          send_id;
  logic                    send_last;
  logic [PAYLOAD_BITS-1:0] rd_data;

  logic [PAYLOAD_BITS-1:0] slot_payloads [SLOTS];

  logic [SLOTS-1:0] slot_bit;
  logic             was_filled;
  logic             was_seen;
  logic [7:0]       drop_next;
  logic [SLOTS-1:0] filled_next;
  logic [SLOTS-1:0] seen_next;
  logic [TW-1:0]    fill_count_next;
  logic [TW-1:0]    seen_count_next;
  logic             drop_limit;
  logic             batch_full;
  logic             interval_up;
  logic             res_free;
  logic             res_load;
  logic             mem_write;
  logic             mem_read;
  logic [IDW-1:0]   first_idx;
  logic [SLOTS-1:0] remaining_after;

  assign slot_bit        = SLOTS'(1) << head_id;
  assign was_filled      = |(filled & slot_bit);
  assign was_seen        = |(seen & slot_bit);
  assign drop_next       = (was_filled && drop_count != 8'hFF) ? drop_count + 8'd1 : drop_count;
  assign filled_next     = filled | slot_bit;
  assign seen_next       = seen | slot_bit;
  assign fill_count_next = was_filled ? fill_count : fill_count + TW'(1);
  assign seen_count_next = was_seen ? seen_count : seen_count + TW'(1);
  assign drop_limit      = (drop_next >= cfg.flush_drops);
  assign batch_full      = (fill_count_next >= threshold);
  assign interval_up     = (ms_since_update >= cfg.update_interval_ms);

  assign res_free = !res_valid || !res_stall;
  assign head_pop = (state == S_IDLE) && head.valid && ((head.op != OP_PASS) || res_free);
  assign res_load = (head_pop && (head.op == OP_PASS)) || ((state == S_SEND) && res_free);

  assign mem_write = head_pop && (head.op == OP_BATCH);
  assign mem_read  = (state == S_READ);

  // lowest pending slot of the flush
  always_comb begin
    first_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (remaining[i]) begin
        first_idx = IDW'(i);
      end
    end
  end

  assign remaining_after = remaining & ~(SLOTS'(1) << first_idx);

  always_ff @(posedge clk) begin
    if (mem_write) begin
      slot_payloads[head_id] <= head_word;
    end
    if (mem_read) begin
      rd_data <= slot_payloads[first_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      filled          <= '0;
      seen            <= '0;
      drop_count      <= '0;
      fill_count      <= '0;
      seen_count      <= '0;
      threshold       <= '0;
      ms_since_update <= '0;
      remaining       <= '0;
      flush_forced    <= 1'b0;
      send_last       <= 1'b0;
      res_valid       <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (head_pop) begin
            case (head.op)
              OP_TICK: begin
                if (ms_since_update != 16'hFFFF) begin
                  ms_since_update <= ms_since_update + 16'd1;
                end
              end
              OP_PASS: begin
                res <= '{robot_id_res:     RES_ID_BITS'(head_id),
                         command_word_res: WORD_BITS'(head_word),
                         last:             1'b1,
                         forced:           1'b0,
                         threshold_now:    THRESHOLD_BITS'(threshold)};
              end
              OP_BATCH: begin
                if (drop_limit || batch_full) begin
                  filled       <= '0;
                  fill_count   <= '0;
                  drop_count   <= '0;
                  remaining    <= filled_next;
                  flush_forced <= drop_limit;
                  state        <= S_READ;
                  if (drop_limit || interval_up) begin
                    threshold  <= seen_count_next;
                    seen       <= '0;
                    seen_count <= '0;
                    if (!drop_limit) begin
                      ms_since_update <= '0;
                    end
                  end else begin
                    seen       <= seen_next;
                    seen_count <= seen_count_next;
                  end
                end else begin
                  filled     <= filled_next;
                  fill_count <= fill_count_next;
                  drop_count <= drop_next;
                  seen       <= seen_next;
                  seen_count <= seen_count_next;
                end
              end
              default: ;
            endcase
          end
        end
        S_READ: begin
          send_id   <= first_idx;
          send_last <= (remaining_after == '0);
          remaining <= remaining_after;
          state     <= S_SEND;
        end
        S_SEND: begin
          if (res_free) begin
            res <= '{robot_id_res:     RES_ID_BITS'(send_id),
                     command_word_res: WORD_BITS'(rd_data),
                     last:             send_last,
                     forced:           flush_forced,
                     threshold_now:    THRESHOLD_BITS'(threshold)};
            state <= send_last ? S_IDLE : S_READ;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_fill_count: assert property (@(posedge clk) disable iff (rst)
    fill_count == TW'($countones(filled)))
    else $error("fill count out of step with filled slots");

  a_seen_count: assert property (@(posedge clk) disable iff (rst)
    seen_count == TW'($countones(seen)))
    else $error("seen count out of step with seen mask");

  a_read_pending: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (remaining != '0))
    else $error("slot read with nothing left to flush");

  a_flush_clear: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (filled == '0 && drop_count == '0))
    else $error("buffer not cleared during flush");
`endif

endmodule

[rtl/adaptive_command_batcher_top.sv]
// Top level of the adaptive command batcher: configuration registers and the two halves.
//
//  port group | direction | handshake            | payload
//  cmd        | in        | cmd_valid / cmd_stall | cmd_t  (kind, robot_id, command_word)
//  res        | out       | res_valid / res_stall | res_t  (id, word, last, forced, threshold)
//  cfg        | in        | cfg_write_en         | cfg_index, cfg_data
//
// Tick, pass-through and non-flushing commands are each taken from the queue in the back end's idle state.
// A flush then reads each filled slot and loads it into the result register, one slot after another.
// A two-item queue sits between front and back; cmd_stall rises only when it is full.
// res_stall holds the result register and the flush sequencer; reset clears state with no sweep.
module adaptive_command_batcher_top
  import acb_pkg::*;
#(
  parameter int SLOTS        = SLOTS_DEFAULT,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_valid,
  output logic                      cmd_stall,
  input  cmd_t                      cmd,
  output logic                      res_valid,
  input  logic                      res_stall,
  output res_t                      res,
  input  logic                      cfg_write_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  acb_cfg_t                  cfg;
  acb_head_t                 head;
  logic [$clog2(SLOTS)-1:0]  head_id;
  logic [PAYLOAD_BITS-1:0]   head_word;
  logic                      head_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.batch_enable       <= BATCH_ENABLE_RESET;
      cfg.flush_drops        <= FLUSH_DROPS_RESET;
      cfg.update_interval_ms <= INTERVAL_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_BATCH_ENABLE:    cfg.batch_enable       <= cfg_data[0];
        REG_FLUSH_DROPS:     cfg.flush_drops        <= cfg_data[7:0];
        REG_UPDATE_INTERVAL: cfg.update_interval_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  acb_front #(
    .SLOTS        (SLOTS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .cmd          (cmd),
    .batch_enable (cfg.batch_enable),
    .head         (head),
    .head_id      (head_id),
    .head_word    (head_word),
    .head_pop     (head_pop)
  );

  acb_back #(
    .SLOTS        (SLOTS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .head_id   (head_id),
    .head_word (head_word),
    .head_pop  (head_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

[sim/adaptive_command_batcher_top_tb.sv]
// Self-checking testbench for the adaptive command batcher top level.
module adaptive_command_batcher_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import acb_pkg::*;

  localparam int NSLOTS        = SLOTS_DEFAULT;
  localparam int QUIET_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 80;
  localparam int HOLD_CYCLES   = 400;
  localparam logic [63:0] ALL_ONES = '1;

  logic                      clk          = 1'b0;
  logic                      rst          = 1'b1;
  logic                      cmd_valid    = 1'b0;
  logic                      cmd_stall;
  cmd_t                      cmd          = '0;
  logic                      res_valid;
  logic                      res_stall    = 1'b0;
  res_t                      res;
  logic                      cfg_write_en = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index    = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data     = '0;

  adaptive_command_batcher_top DUT (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // shadow of the block
  logic [63:0] slot_word [NSLOTS];
  logic [15:0] filled_slots;
  logic [15:0] seen_slots;
  logic [7:0]  drop_tally;
  logic [4:0]  thresh;
  logic [15:0] ms_count;
  logic        en_batch;
  logic [7:0]  drop_limit;
  logic [15:0] refresh_ms;

  cmd_t cmd_backlog [$];
  res_t due_cmds [$];
  res_t want;

  int send_idle_pct  = 24;
  int recv_stall_pct = 88;
  int error_count    = 0;
  int quiet_cycles   = 0;
  int hold_left      = 0;
  logic pressure_armed = 1'b0;
  logic pressure_done  = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic emit_buffer(input logic forced);
    logic [15:0] remaining;
    int i;
    remaining = filled_slots;
    for (i = 0; i < NSLOTS; i++) begin
      if (remaining[i]) begin
        remaining[i] = 1'b0;
        due_cmds.push_back('{robot_id_res: i[3:0], command_word_res: slot_word[i],
                             last: (remaining == 16'd0), forced: forced,
                             threshold_now: thresh});
      end
    end
    filled_slots = '0;
    drop_tally   = '0;
  endtask

  task automatic batch_command(input cmd_t c);
    logic [15:0] id_bit;
    logic [3:0]  slot;
    id_bit = '0;
    slot   = c.robot_id[3:0];
    if (c.kind == KIND_TICK) begin
      if (ms_count != 16'hFFFF) ms_count++;
      return;
    end
    if (c.robot_id >= NSLOTS) return;
    if (!en_batch) begin
      due_cmds.push_back('{robot_id_res: slot, command_word_res: c.command_word,
                           last: 1'b1, forced: 1'b0, threshold_now: thresh});
      return;
    end
    id_bit[slot] = 1'b1;
    if ((filled_slots & id_bit) != 0 && drop_tally != 8'hFF) drop_tally++;
    slot_word[slot] = c.command_word;
    filled_slots |= id_bit;
    seen_slots   |= id_bit;
    if (drop_tally >= drop_limit) begin
      thresh     = 5'($countones(seen_slots));
      seen_slots = '0;
      emit_buffer(1'b1);
    end else if ($countones(filled_slots) >= thresh) begin
      if (ms_count >= refresh_ms) begin
        thresh     = 5'($countones(seen_slots));
        seen_slots = '0;
        ms_count   = '0;
      end
      emit_buffer(1'b0);
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && !cmd_stall) batch_command(cmd);
      if (!cmd_valid || !cmd_stall) begin
        if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cmd       <= cmd_backlog.pop_front();
          cmd_valid <= 1'b1;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (due_cmds.size() == 0) begin
        report_mismatch($sformatf("result for id %0d with nothing due", res.robot_id_res));
      end else begin
        want = due_cmds.pop_front();
        if (res.robot_id_res !== want.robot_id_res)
          report_mismatch($sformatf("robot_id_res %0d, want %0d",
                                    res.robot_id_res, want.robot_id_res));
        if (res.command_word_res !== want.command_word_res)
          report_mismatch($sformatf("command_word_res %h, want %h",
                                    res.command_word_res, want.command_word_res));
        if (res.last !== want.last)
          report_mismatch($sformatf("last %b, want %b", res.last, want.last));
        if (res.forced !== want.forced)
          report_mismatch($sformatf("forced %b, want %b", res.forced, want.forced));
        if (res.threshold_now !== want.threshold_now)
          report_mismatch($sformatf("threshold_now %0d, want %0d",
                                    res.threshold_now, want.threshold_now));
      end
    end
    if (pressure_armed && !pressure_done) begin
      pressure_done <= 1'b1;
      hold_left     <= HOLD_CYCLES;
      res_stall     <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      res_stall <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("** adaptive_command_batcher_top: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic queue_cmd(input logic kind, input logic [7:0] id, input logic [63:0] word);
    cmd_backlog.push_back('{kind: kind, robot_id: id, command_word: word});
  endtask

  function automatic logic [63:0] rand_word();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return ALL_ONES;
    if (sel == 1) return '0;
    return {$urandom, $urandom};
  endfunction

  // n counts ticks and in-range commands; discarded ids come on top
  task automatic queue_random(input int n, input int tick_pct, input int id_span);
    int done;
    int r;
    done = 0;
    while (done < n) begin
      r = $urandom_range(0, 99);
      if (r < tick_pct) begin
        queue_cmd(KIND_TICK, 8'($urandom_range(0, 255)), rand_word());
        done++;
      end else if (r < tick_pct + 8) begin
        queue_cmd(KIND_COMMAND, 8'($urandom_range(NSLOTS, 255)), rand_word());
      end else begin
        queue_cmd(KIND_COMMAND, 8'($urandom_range(0, id_span)), rand_word());
        done++;
      end
    end
  endtask

  task automatic drain();
    while (cmd_backlog.size() != 0 || cmd_valid || due_cmds.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input acb_reg_e idx, input logic [15:0] val);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= val;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    case (idx)
      REG_BATCH_ENABLE:    en_batch   = val[0];
      REG_FLUSH_DROPS:     drop_limit = val[7:0];
      REG_UPDATE_INTERVAL: refresh_ms = val;
      default: ;
    endcase
  endtask

  initial begin
    filled_slots = '0;
    seen_slots   = '0;
    drop_tally   = '0;
    thresh       = '0;
    ms_count     = '0;
    en_batch     = BATCH_ENABLE_RESET;
    drop_limit   = FLUSH_DROPS_RESET;
    refresh_ms   = INTERVAL_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // zero threshold, discarded ids, ticks
    queue_cmd(KIND_COMMAND, 8'd0, ALL_ONES);
    queue_cmd(KIND_COMMAND, 8'd15, 64'd0);
    queue_cmd(KIND_COMMAND, 8'd16, ALL_ONES);
    queue_cmd(KIND_COMMAND, 8'd255, ALL_ONES);
    queue_cmd(KIND_TICK, 8'd255, ALL_ONES);
    queue_cmd(KIND_TICK, 8'd0, 64'd0);
    drain();
    // threshold refresh, an overwrite, then a normal flush
    write_reg(REG_UPDATE_INTERVAL, 16'd0);
    queue_cmd(KIND_COMMAND, 8'd7, rand_word());
    queue_cmd(KIND_COMMAND, 8'd1, rand_word());
    queue_cmd(KIND_COMMAND, 8'd2, rand_word());
    queue_cmd(KIND_COMMAND, 8'd1, rand_word());
    queue_cmd(KIND_COMMAND, 8'd3, rand_word());
    drain();
    write_reg(REG_FLUSH_DROPS, 16'd1);
    queue_cmd(KIND_COMMAND, 8'd4, rand_word());
    queue_cmd(KIND_COMMAND, 8'd4, rand_word());
    drain();
    write_reg(REG_FLUSH_DROPS, 16'd0);
    queue_cmd(KIND_COMMAND, 8'd5, rand_word());
    drain();
    write_reg(REG_BATCH_ENABLE, 16'd0);
    queue_cmd(KIND_COMMAND, 8'd9, rand_word());
    queue_cmd(KIND_COMMAND, 8'd20, rand_word());
    queue_cmd(KIND_COMMAND, 8'd15, ALL_ONES);
    drain();

    write_reg(REG_BATCH_ENABLE, 16'd1);
    write_reg(REG_FLUSH_DROPS, 16'd4);
    write_reg(REG_UPDATE_INTERVAL, 16'd3);
    queue_random(60, 20, 15);
    drain();
    write_reg(REG_FLUSH_DROPS, 16'd255);
    write_reg(REG_UPDATE_INTERVAL, 16'd0);
    queue_random(60, 15, 7);
    drain();

    send_idle_pct  = 88;
    recv_stall_pct = 24;
    write_reg(REG_BATCH_ENABLE, 16'd0);
    write_reg(REG_FLUSH_DROPS, 16'd1);
    write_reg(REG_UPDATE_INTERVAL, 16'hFFFF);
    queue_random(50, 10, 15);
    drain();
    write_reg(REG_BATCH_ENABLE, 16'd1);
    write_reg(REG_UPDATE_INTERVAL, 16'd10);
    queue_random(60, 30, 15);
    drain();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(REG_FLUSH_DROPS, 16'($urandom_range(2, 8)));
    write_reg(REG_UPDATE_INTERVAL, 16'($urandom_range(0, 20)));
    queue_random(60, 15, 15);
    pressure_armed = 1'b1;
    drain();
    // longest interval: normal flushes keep the threshold
    write_reg(REG_FLUSH_DROPS, 16'd255);
    write_reg(REG_UPDATE_INTERVAL, 16'hFFFF);
    queue_random(30, 10, 15);
    drain();

    if (due_cmds.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", due_cmds.size()));
    if (error_count == 0) begin
      $display("** adaptive_command_batcher_top: PASSED **");
    end else begin
      $display("** adaptive_command_batcher_top: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/acb_pkg.sv
rtl/acb_front.sv
rtl/acb_back.sv
rtl/adaptive_command_batcher_top.sv
sim/adaptive_command_batcher_top_tb.sv
